>>> rtl/tfqs_pkg.sv
// Shared types and codes for the task frame queue scheduler.
// Holds operation, status and lifecycle codes, queue indexes and port widths.
// No dependencies.
package tfqs_pkg;

	localparam int FRAME_COUNT_DEF = 64;

	// Field widths of the stream words
	localparam int FUNC_W     = 3;
	localparam int FID_W      = 6;
	localparam int STS_W      = 2;
	localparam int LC_W       = 3;
	localparam int OUT_LINK_W = 7;
	localparam int SPARK_W    = 32;
	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 72;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_SPARK   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_UNSPARK = 3'd1;
	localparam logic [FUNC_W-1:0] FN_RUN     = 3'd2;
	localparam logic [FUNC_W-1:0] FN_BLOCK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_UNBLOCK = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DONE    = 3'd5;

	// Result status codes
	localparam logic [STS_W-1:0] STS_APPLIED = 2'd0;
	localparam logic [STS_W-1:0] STS_IGNORED = 2'd1;
	localparam logic [STS_W-1:0] STS_ILLEGAL = 2'd2;

	// Frame lifecycle codes
	localparam logic [LC_W-1:0] LC_NEW     = 3'd0;
	localparam logic [LC_W-1:0] LC_SPARKED = 3'd1;
	localparam logic [LC_W-1:0] LC_RUNNING = 3'd2;
	localparam logic [LC_W-1:0] LC_BLOCKED = 3'd3;
	localparam logic [LC_W-1:0] LC_DONE    = 3'd4;

	// Queue indexes
	localparam int Q_SPARKED  = 0;
	localparam int Q_RUNNABLE = 1;
	localparam int Q_BLOCKED  = 2;
	localparam int Q_NUM      = 3;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_READ,
		FSM_WR_A,
		FSM_WR_B,
		FSM_HOLD
	} fsm_t;

endpackage

>>> rtl/tfqs_ram.sv
// Generic synchronous RAM: one write port with a bit mask, one registered read port.
// Standalone, no package dependency.
module tfqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_mask,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wr_mask[i]) begin
					mem[wr_addr][i] <= wr_data[i];
				end
			end
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/task_frame_queue_scheduler_core.sv
// Top level of the task frame queue scheduler: lifecycle and link memories, queue ends, sequencer.
// Depends on tfqs_pkg and tfqs_ram.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   func, frame_id (one operation word)
// m_*      out  m_tvalid/m_tready   status, frame_state, queue heads/counts, spark_total
//
// Each accepted word runs in order through accept and read of the frame entry, write of the
// frame entry, write of the unlinked neighbors, write of the old head or tail. The single
// write port of each link memory is why these writes take separate steps.
// After reset the block sweeps every memory entry back to a new, unlinked frame with s_tready low.
// A result waits in the output register; the next word is taken meanwhile, and its own
// result holds in the sequencer until the output register frees up.
module task_frame_queue_scheduler_core import tfqs_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [2:0] func, [8:3] frame_id, [15:9] zero
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [1:0] status, [4:2] frame_state, [11:5] runnable_head, [18:12] runnable_count,
	// [25:19] sparked_head, [32:26] sparked_count, [39:33] blocked_count, [71:40] spark_total
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int AW   = $clog2(FRAME_COUNT);
	localparam int LW   = $clog2(FRAME_COUNT + 1);
	localparam int M1_W = LC_W + LW;
	localparam logic [LW-1:0]   NIL       = LW'(FRAME_COUNT);
	localparam logic [AW-1:0]   LAST_ADDR = AW'(FRAME_COUNT - 1);
	localparam logic [M1_W-1:0] MASK_PREV = {{LC_W{1'b0}}, {LW{1'b1}}};
	localparam logic [M1_W-1:0] MASK_ALL  = {M1_W{1'b1}};

	// Sequencer and captured word
	fsm_t              fsm_q, fsm_d;
	logic [AW-1:0]     clr_cnt_q;
	logic [FUNC_W-1:0] func_q;
	logic [AW-1:0]     fid_q;
	logic              fid_ok_q;
	logic [FID_W-1:0]  fid_in;

	// Queue ends, sizes and the spark counter
	logic [LW-1:0]      first_q [Q_NUM];
	logic [LW-1:0]      last_q  [Q_NUM];
	logic [LW-1:0]      size_q  [Q_NUM];
	logic [LW-1:0]      first_d [Q_NUM];
	logic [LW-1:0]      last_d  [Q_NUM];
	logic [LW-1:0]      size_d  [Q_NUM];
	logic [SPARK_W-1:0] spark_q;

	// Pending neighbor writes
	logic [LW-1:0] lnk_n_q, lnk_p_q, push_lnk_q;
	logic          wa_n_en_q, wa_p_en_q, wb_h_en_q, wb_t_en_q;

	// Result fields held until the output register takes them
	logic [STS_W-1:0] sts_q;
	logic [LC_W-1:0]  fst_q;
	logic             m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// Memory ports: m1 holds {lifecycle, prev}, m2 holds next
	logic            m1_wr_en, m2_wr_en, rd_en;
	logic [AW-1:0]   m1_wr_addr, m2_wr_addr, rd_addr;
	logic [M1_W-1:0] m1_wr_mask, m1_wr_data, m1_rd_data;
	logic [LW-1:0]   m2_wr_data, m2_rd_data;
	logic            load_out;

	// Decode of the frame entry
	logic [LC_W-1:0]  s_lc, lc_c, fst_c;
	logic [LW-1:0]    s_prev, s_next, f_link, push_lnk_c, f_prev_c, f_next_c;
	logic [STS_W-1:0] sts_c;
	logic             applied_c, spark_inc_c;
	logic [Q_NUM-1:0] unl_c, ph_c, pt_c;
	logic             out_free;

	assign fid_in   = s_tdata[FUNC_W +: FID_W];
	assign s_lc     = m1_rd_data[LW +: LC_W];
	assign s_prev   = m1_rd_data[LW-1:0];
	assign s_next   = m2_rd_data;
	assign f_link   = LW'(fid_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (fsm_q == FSM_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tfqs_ram #(
		.WIDTH(M1_W),
		.DEPTH(FRAME_COUNT)
	) u_lc_prev_ram (
		.clk    (clk),
		.wr_en  (m1_wr_en),
		.wr_addr(m1_wr_addr),
		.wr_mask(m1_wr_mask),
		.wr_data(m1_wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(m1_rd_data)
	);

	tfqs_ram #(
		.WIDTH(LW),
		.DEPTH(FRAME_COUNT)
	) u_next_ram (
		.clk    (clk),
		.wr_en  (m2_wr_en),
		.wr_addr(m2_wr_addr),
		.wr_mask({LW{1'b1}}),
		.wr_data(m2_wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(m2_rd_data)
	);

	// Decode the operation against the frame's current state
	always_comb begin
		sts_c       = STS_IGNORED;
		lc_c        = s_lc;
		applied_c   = 1'b0;
		spark_inc_c = 1'b0;
		unl_c       = '0;
		ph_c        = '0;
		pt_c        = '0;
		if (fid_ok_q) begin
			case (func_q)
				FN_SPARK: begin
					if (s_lc == LC_NEW) begin
						pt_c[Q_SPARKED] = 1'b1;
						lc_c            = LC_SPARKED;
						spark_inc_c     = 1'b1;
						applied_c       = 1'b1;
					end
				end
				FN_UNSPARK: begin
					if (s_lc == LC_SPARKED) begin
						unl_c[Q_SPARKED] = 1'b1;
						lc_c             = LC_NEW;
						applied_c        = 1'b1;
					end else if (s_lc != LC_NEW) begin
						sts_c = STS_ILLEGAL;
					end
				end
				FN_RUN: begin
					if (s_lc == LC_SPARKED || s_lc == LC_NEW) begin
						unl_c[Q_SPARKED] = (s_lc == LC_SPARKED);
						ph_c[Q_RUNNABLE] = 1'b1;
						lc_c             = LC_RUNNING;
						applied_c        = 1'b1;
					end
				end
				FN_BLOCK: begin
					if (s_lc == LC_RUNNING) begin
						unl_c[Q_RUNNABLE] = 1'b1;
						ph_c[Q_BLOCKED]   = 1'b1;
						lc_c              = LC_BLOCKED;
						applied_c         = 1'b1;
					end else begin
						sts_c = STS_ILLEGAL;
					end
				end
				FN_UNBLOCK: begin
					if (s_lc == LC_BLOCKED) begin
						unl_c[Q_BLOCKED] = 1'b1;
						ph_c[Q_RUNNABLE] = 1'b1;
						lc_c             = LC_RUNNING;
						applied_c        = 1'b1;
					end else begin
						sts_c = STS_ILLEGAL;
					end
				end
				FN_DONE: begin
					if (s_lc == LC_RUNNING) begin
						unl_c[Q_RUNNABLE] = 1'b1;
						lc_c              = LC_DONE;
						applied_c         = 1'b1;
					end else begin
						sts_c = STS_ILLEGAL;
					end
				end
				default: begin
				end
			endcase
		end
		if (applied_c) begin
			sts_c = STS_APPLIED;
		end
		fst_c = fid_ok_q ? lc_c : LC_NEW;
	end

	// Queue end updates; unlink and push always touch different queues
	always_comb begin
		push_lnk_c = NIL;
		for (int q = 0; q < Q_NUM; q++) begin
			first_d[q] = first_q[q];
			last_d[q]  = last_q[q];
			size_d[q]  = size_q[q];
			if (unl_c[q]) begin
				if (first_q[q] == f_link) begin
					first_d[q] = s_next;
				end
				if (last_q[q] == f_link) begin
					last_d[q] = s_prev;
				end
				if (size_q[q] != '0) begin
					size_d[q] = size_q[q] - LW'(1);
				end
			end
			if (ph_c[q]) begin
				push_lnk_c = first_q[q];
				if (first_q[q] == NIL) begin
					last_d[q] = f_link;
				end
				first_d[q] = f_link;
				size_d[q]  = size_q[q] + LW'(1);
			end
			if (pt_c[q]) begin
				push_lnk_c = last_q[q];
				if (last_q[q] == NIL) begin
					first_d[q] = f_link;
				end
				last_d[q] = f_link;
				size_d[q] = size_q[q] + LW'(1);
			end
		end
		f_prev_c = (|pt_c) ? push_lnk_c : NIL;
		f_next_c = (|ph_c) ? push_lnk_c : NIL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_CLEAR;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	// Sequencer: next state and memory port control
	always_comb begin
		fsm_d      = fsm_q;
		rd_en      = 1'b0;
		rd_addr    = AW'(fid_in);
		m1_wr_en   = 1'b0;
		m1_wr_addr = fid_q;
		m1_wr_mask = MASK_ALL;
		m1_wr_data = {lc_c, f_prev_c};
		m2_wr_en   = 1'b0;
		m2_wr_addr = fid_q;
		m2_wr_data = f_next_c;
		load_out   = 1'b0;
		case (fsm_q)
			FSM_CLEAR: begin
				// Sweep every entry back to a new, unlinked frame
				m1_wr_en   = 1'b1;
				m1_wr_addr = clr_cnt_q;
				m1_wr_data = {LC_NEW, NIL};
				m2_wr_en   = 1'b1;
				m2_wr_addr = clr_cnt_q;
				m2_wr_data = NIL;
				if (clr_cnt_q == LAST_ADDR) begin
					fsm_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (s_tvalid) begin
					rd_en = 1'b1;
					fsm_d = FSM_READ;
				end
			end
			FSM_READ: begin
				// Write the frame's own entry
				m1_wr_en = applied_c;
				m2_wr_en = applied_c;
				fsm_d    = FSM_WR_A;
			end
			FSM_WR_A: begin
				// Splice the old neighbors together
				m1_wr_en   = wa_n_en_q;
				m1_wr_addr = AW'(lnk_n_q);
				m1_wr_mask = MASK_PREV;
				m1_wr_data = {LC_NEW, lnk_p_q};
				m2_wr_en   = wa_p_en_q;
				m2_wr_addr = AW'(lnk_p_q);
				m2_wr_data = lnk_n_q;
				fsm_d      = FSM_WR_B;
			end
			FSM_WR_B: begin
				// Link the old head back to the frame, or the old tail forward to it
				m1_wr_en   = wb_h_en_q;
				m1_wr_addr = AW'(push_lnk_q);
				m1_wr_mask = MASK_PREV;
				m1_wr_data = {LC_NEW, f_link};
				m2_wr_en   = wb_t_en_q;
				m2_wr_addr = AW'(push_lnk_q);
				m2_wr_data = f_link;
				if (out_free) begin
					load_out = 1'b1;
					fsm_d    = FSM_IDLE;
				end else begin
					fsm_d = FSM_HOLD;
				end
			end
			FSM_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					fsm_d    = FSM_IDLE;
				end
			end
			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase
	end

	// Control state: clear counter, queue ends, spark counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			spark_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int q = 0; q < Q_NUM; q++) begin
				first_q[q] <= NIL;
				last_q[q]  <= NIL;
				size_q[q]  <= '0;
			end
		end else begin
			if (fsm_q == FSM_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (fsm_q == FSM_READ) begin
				for (int q = 0; q < Q_NUM; q++) begin
					first_q[q] <= first_d[q];
					last_q[q]  <= last_d[q];
					size_q[q]  <= size_d[q];
				end
				if (spark_inc_c) begin
					spark_q <= spark_q + SPARK_W'(1);
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (fsm_q == FSM_IDLE && s_tvalid) begin
			func_q   <= s_tdata[FUNC_W-1:0];
			fid_q    <= AW'(fid_in);
			fid_ok_q <= (int'(fid_in) < FRAME_COUNT);
		end
		if (fsm_q == FSM_READ) begin
			sts_q      <= sts_c;
			fst_q      <= fst_c;
			lnk_n_q    <= s_next;
			lnk_p_q    <= s_prev;
			push_lnk_q <= push_lnk_c;
			wa_n_en_q  <= (|unl_c) && (s_next != NIL);
			wa_p_en_q  <= (|unl_c) && (s_prev != NIL);
			wb_h_en_q  <= (|ph_c) && (push_lnk_c != NIL);
			wb_t_en_q  <= (|pt_c) && (push_lnk_c != NIL);
		end
		// Queue ends already hold this word's outcome when the result loads
		if (load_out) begin
			m_tdata_q <= {spark_q,
				OUT_LINK_W'(size_q[Q_BLOCKED]),
				OUT_LINK_W'(size_q[Q_SPARKED]),
				OUT_LINK_W'(first_q[Q_SPARKED]),
				OUT_LINK_W'(size_q[Q_RUNNABLE]),
				OUT_LINK_W'(first_q[Q_RUNNABLE]),
				fst_q, sts_q};
		end
	end

endmodule

>>> tb/testbench.sv
// Self-checking bench for task_frame_queue_scheduler_core: drives operation words on the
// s_* stream and checks every m_* result against a built-in model of the frame lifecycle
// and its three linked queues. Depends on tfqs_pkg and the scheduler RTL only.
module testbench import tfqs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES      = FRAME_COUNT_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 24;
	localparam int PHASE_WORDS = 172;

	localparam logic [OUT_LINK_W-1:0] NULL_LINK = OUT_LINK_W'(FRAMES);

	// Unused operation codes; the block must treat them as no-ops
	localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

	// Result word, listed from the top bits down so that it overlays m_tdata directly
	typedef struct packed {
		logic [SPARK_W-1:0]    spark_total;
		logic [OUT_LINK_W-1:0] blocked_count;
		logic [OUT_LINK_W-1:0] sparked_count;
		logic [OUT_LINK_W-1:0] sparked_head;
		logic [OUT_LINK_W-1:0] runnable_count;
		logic [OUT_LINK_W-1:0] runnable_head;
		logic [LC_W-1:0]       frame_state;
		logic [STS_W-1:0]      status;
	} sched_result_t;

	// One directed stimulus row; want is used only when typed is set
	typedef struct packed {
		logic [FUNC_W-1:0] fn;
		logic [FID_W-1:0]  fid;
		logic              typed;
		sched_result_t     want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	task_frame_queue_scheduler_core #(.FRAME_COUNT(FRAMES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state: lifecycle per frame, doubly linked queues, spark counter
	logic [LC_W-1:0]       frame_life [FRAMES];
	logic [OUT_LINK_W-1:0] next_frame [FRAMES];
	logic [OUT_LINK_W-1:0] prev_frame [FRAMES];
	logic [OUT_LINK_W-1:0] q_first [Q_NUM];
	logic [OUT_LINK_W-1:0] q_last [Q_NUM];
	logic [OUT_LINK_W-1:0] q_len [Q_NUM];
	logic [SPARK_W-1:0]    spark_count;

	sched_result_t pending_results [$];
	stim_row_t     directed_rows [$];
	int            fault_count = 0;
	int            cycle_count = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;

	function automatic void clear_model();
		for (int i = 0; i < FRAMES; i++) begin
			frame_life[i] = LC_NEW;
			next_frame[i] = NULL_LINK;
			prev_frame[i] = NULL_LINK;
		end
		for (int q = 0; q < Q_NUM; q++) begin
			q_first[q] = NULL_LINK;
			q_last[q]  = NULL_LINK;
			q_len[q]   = '0;
		end
		spark_count = '0;
	endfunction

	function automatic void link_at_head(input int q, input logic [OUT_LINK_W-1:0] f);
		logic [OUT_LINK_W-1:0] old_head;
		old_head                   = q_first[q];
		prev_frame[f[FID_W-1:0]]   = NULL_LINK;
		next_frame[f[FID_W-1:0]]   = old_head;
		if (old_head < NULL_LINK) begin
			prev_frame[old_head[FID_W-1:0]] = f;
		end else begin
			q_last[q] = f;
		end
		q_first[q] = f;
		q_len[q]   = q_len[q] + OUT_LINK_W'(1);
	endfunction

	function automatic void link_at_tail(input int q, input logic [OUT_LINK_W-1:0] f);
		logic [OUT_LINK_W-1:0] old_tail;
		old_tail                 = q_last[q];
		next_frame[f[FID_W-1:0]] = NULL_LINK;
		prev_frame[f[FID_W-1:0]] = old_tail;
		if (old_tail < NULL_LINK) begin
			next_frame[old_tail[FID_W-1:0]] = f;
		end else begin
			q_first[q] = f;
		end
		q_last[q] = f;
		q_len[q]  = q_len[q] + OUT_LINK_W'(1);
	endfunction

	function automatic void unlink(input int q, input logic [OUT_LINK_W-1:0] f);
		logic [OUT_LINK_W-1:0] nf;
		logic [OUT_LINK_W-1:0] pf;
		nf = next_frame[f[FID_W-1:0]];
		pf = prev_frame[f[FID_W-1:0]];
		if (q_first[q] == f) q_first[q] = nf;
		if (q_last[q] == f) q_last[q] = pf;
		if (nf < NULL_LINK) prev_frame[nf[FID_W-1:0]] = pf;
		if (pf < NULL_LINK) next_frame[pf[FID_W-1:0]] = nf;
		next_frame[f[FID_W-1:0]] = NULL_LINK;
		prev_frame[f[FID_W-1:0]] = NULL_LINK;
		if (q_len[q] > 0) q_len[q] = q_len[q] - OUT_LINK_W'(1);
	endfunction

	// Advance the model by one operation word and return the result it must produce
	function automatic sched_result_t apply_sched_op(input logic [FUNC_W-1:0] fn,
			input logic [FID_W-1:0] fid);
		sched_result_t         res;
		logic [OUT_LINK_W-1:0] f;
		logic [LC_W-1:0]       cur;
		f          = OUT_LINK_W'(fid);
		cur        = frame_life[fid];
		res.status = STS_IGNORED;
		case (fn)
			FN_SPARK: begin
				if (cur == LC_NEW) begin
					link_at_tail(Q_SPARKED, f);
					frame_life[fid] = LC_SPARKED;
					spark_count     = spark_count + SPARK_W'(1);
					res.status      = STS_APPLIED;
				end
			end
			FN_UNSPARK: begin
				if (cur == LC_SPARKED) begin
					unlink(Q_SPARKED, f);
					frame_life[fid] = LC_NEW;
					res.status      = STS_APPLIED;
				end else if (cur != LC_NEW) begin
					res.status = STS_ILLEGAL;
				end
			end
			FN_RUN: begin
				if (cur == LC_SPARKED || cur == LC_NEW) begin
					if (cur == LC_SPARKED) unlink(Q_SPARKED, f);
					link_at_head(Q_RUNNABLE, f);
					frame_life[fid] = LC_RUNNING;
					res.status      = STS_APPLIED;
				end
			end
			FN_BLOCK: begin
				if (cur == LC_RUNNING) begin
					unlink(Q_RUNNABLE, f);
					link_at_head(Q_BLOCKED, f);
					frame_life[fid] = LC_BLOCKED;
					res.status      = STS_APPLIED;
				end else begin
					res.status = STS_ILLEGAL;
				end
			end
			FN_UNBLOCK: begin
				if (cur == LC_BLOCKED) begin
					unlink(Q_BLOCKED, f);
					link_at_head(Q_RUNNABLE, f);
					frame_life[fid] = LC_RUNNING;
					res.status      = STS_APPLIED;
				end else begin
					res.status = STS_ILLEGAL;
				end
			end
			FN_DONE: begin
				if (cur == LC_RUNNING) begin
					unlink(Q_RUNNABLE, f);
					frame_life[fid] = LC_DONE;
					res.status      = STS_APPLIED;
				end else begin
					res.status = STS_ILLEGAL;
				end
			end
			default: ;
		endcase
		res.frame_state    = frame_life[fid];
		res.runnable_head  = q_first[Q_RUNNABLE];
		res.runnable_count = q_len[Q_RUNNABLE];
		res.sparked_head   = q_first[Q_SPARKED];
		res.sparked_count  = q_len[Q_SPARKED];
		res.blocked_count  = q_len[Q_BLOCKED];
		res.spark_total    = spark_count;
		return res;
	endfunction

	// Expected word while the runnable and blocked queues are still empty
	function automatic sched_result_t at_rest(input logic [STS_W-1:0] sts,
			input logic [LC_W-1:0] st, input logic [OUT_LINK_W-1:0] sp_head,
			input logic [OUT_LINK_W-1:0] sp_count, input logic [SPARK_W-1:0] total);
		sched_result_t res;
		res.status         = sts;
		res.frame_state    = st;
		res.runnable_head  = NULL_LINK;
		res.runnable_count = '0;
		res.sparked_head   = sp_head;
		res.sparked_count  = sp_count;
		res.blocked_count  = '0;
		res.spark_total    = total;
		return res;
	endfunction

	// Directed rows: error paths and the reserved codes straight after reset, then frames 0,
	// 63 and 42 walked through every lifecycle transition and the terminal done state
	task automatic load_directed();
		sched_result_t quiet_ign;
		sched_result_t quiet_ill;
		quiet_ign = at_rest(STS_IGNORED, LC_NEW, NULL_LINK, '0, '0);
		quiet_ill = at_rest(STS_ILLEGAL, LC_NEW, NULL_LINK, '0, '0);
		directed_rows.push_back('{FN_UNSPARK, 6'd0,  1'b1, quiet_ign});
		directed_rows.push_back('{FN_BLOCK,   6'd63, 1'b1, quiet_ill});
		directed_rows.push_back('{FN_UNBLOCK, 6'd0,  1'b1, quiet_ill});
		directed_rows.push_back('{FN_DONE,    6'd63, 1'b1, quiet_ill});
		directed_rows.push_back('{FN_RSVD6,   6'd21, 1'b1, quiet_ign});
		directed_rows.push_back('{FN_RSVD7,   6'd42, 1'b1, quiet_ign});
		directed_rows.push_back('{FN_SPARK,   6'd0,  1'b1,
			at_rest(STS_APPLIED, LC_SPARKED, 7'd0, 7'd1, 32'd1)});
		directed_rows.push_back('{FN_SPARK,   6'd63, 1'b0, '0});
		directed_rows.push_back('{FN_SPARK,   6'd0,  1'b0, '0}); // already sparked
		directed_rows.push_back('{FN_UNSPARK, 6'd0,  1'b0, '0}); // unlink sparked head
		directed_rows.push_back('{FN_RUN,     6'd63, 1'b0, '0}); // sparked to running
		directed_rows.push_back('{FN_RUN,     6'd42, 1'b0, '0}); // new to running
		directed_rows.push_back('{FN_RUN,     6'd42, 1'b0, '0}); // running: no-op
		directed_rows.push_back('{FN_BLOCK,   6'd63, 1'b0, '0}); // take from queue tail
		directed_rows.push_back('{FN_UNSPARK, 6'd63, 1'b0, '0}); // blocked: rejected
		directed_rows.push_back('{FN_RUN,     6'd63, 1'b0, '0}); // blocked: no-op
		directed_rows.push_back('{FN_UNBLOCK, 6'd63, 1'b0, '0});
		directed_rows.push_back('{FN_DONE,    6'd42, 1'b0, '0});
		directed_rows.push_back('{FN_UNSPARK, 6'd42, 1'b0, '0}); // done: rejected
		directed_rows.push_back('{FN_SPARK,   6'd42, 1'b0, '0}); // done: no-op
		directed_rows.push_back('{FN_BLOCK,   6'd42, 1'b0, '0});
		directed_rows.push_back('{FN_RSVD7,   6'd42, 1'b0, '0}); // reports done state
		directed_rows.push_back('{FN_UNBLOCK, 6'd21, 1'b0, '0});
	endtask

	// Offer one word, with random idle cycles ahead of it, and hold it until accepted.
	// s_tvalid is left high on return so back-to-back words need no extra assignment.
	task automatic send_word(input stim_row_t row);
		sched_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W-FUNC_W-FID_W){1'b0}}, row.fid, row.fn};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = apply_sched_op(row.fn, row.fid);
		pending_results.push_back(row.typed ? row.want : predicted);
	endtask

	// Mostly legal transitions for the frame's current state; the rest is noise
	task automatic pick_random(output stim_row_t row);
		int roll;
		int tries;
		row = '0;
		if ($urandom_range(99) < 15) begin
			row.fn  = FUNC_W'($urandom_range(7));
			row.fid = FID_W'($urandom_range(FRAMES - 1));
		end else begin
			row.fid = FID_W'($urandom_range(FRAMES - 1));
			for (tries = 0; tries < 8 && frame_life[row.fid] == LC_DONE; tries++)
				row.fid = FID_W'($urandom_range(FRAMES - 1));
			roll = $urandom_range(99);
			case (frame_life[row.fid])
				LC_NEW:     row.fn = (roll < 65) ? FN_SPARK : FN_RUN;
				LC_SPARKED: row.fn = (roll < 35) ? FN_UNSPARK : FN_RUN;
				LC_RUNNING: row.fn = (roll < 12) ? FN_DONE : FN_BLOCK;
				LC_BLOCKED: row.fn = FN_UNBLOCK;
				default:    row.fn = FUNC_W'($urandom_range(7));
			endcase
		end
	endtask

	function automatic void report_field(input string name, input logic [SPARK_W-1:0] want,
			input logic [SPARK_W-1:0] got);
		fault_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
	endfunction

	// Result side: check each accepted word against the oldest expectation, then
	// pick m_tready for the next cycle
	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_results.size() == 0) begin
					fault_count++;
					$display("%0t: result word with none expected, got %h", $time, m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status)
						report_field("status", SPARK_W'(want.status),
							SPARK_W'(got.status));
					if (got.frame_state !== want.frame_state)
						report_field("frame_state", SPARK_W'(want.frame_state),
							SPARK_W'(got.frame_state));
					if (got.runnable_head !== want.runnable_head)
						report_field("runnable_head", SPARK_W'(want.runnable_head),
							SPARK_W'(got.runnable_head));
					if (got.runnable_count !== want.runnable_count)
						report_field("runnable_count", SPARK_W'(want.runnable_count),
							SPARK_W'(got.runnable_count));
					if (got.sparked_head !== want.sparked_head)
						report_field("sparked_head", SPARK_W'(want.sparked_head),
							SPARK_W'(got.sparked_head));
					if (got.sparked_count !== want.sparked_count)
						report_field("sparked_count", SPARK_W'(want.sparked_count),
							SPARK_W'(got.sparked_count));
					if (got.blocked_count !== want.blocked_count)
						report_field("blocked_count", SPARK_W'(want.blocked_count),
							SPARK_W'(got.blocked_count));
					if (got.spark_total !== want.spark_total)
						report_field("spark_total", want.spark_total, got.spark_total);
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: covers the clearing sweep and the slowest legal handshake pattern many times
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        sweep_base;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		clear_model();
		load_directed();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: no idling on either side
		foreach (directed_rows[i]) send_word(directed_rows[i]);

		// Spark every frame once to push the sparked queue near full
		sweep_base = $urandom_range(FRAMES - 1);
		for (int i = 0; i < FRAMES; i++) begin
			row     = '0;
			row.fn  = FN_SPARK;
			row.fid = FID_W'((sweep_base + i) % FRAMES);
			send_word(row);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick_random(row);
				send_word(row);
			end
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every expected word, then a short quiet window
		while (pending_results.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fault_count == 0 && pending_results.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
